// ===== src/hws_pkg.sv =====
// Package for the Hamming window search block: operation and register codes,
// the per-cell control struct and the adder tree grouping constants.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package hws_pkg;

   // Request operation codes.
   localparam logic OP_PATTERN = 1'b0;
   localparam logic OP_TEXT    = 1'b1;

   // Configuration register indexes.
   localparam int  CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MISMATCH_THRESHOLD = 1'b1;

   // Field widths fixed by the interface.
   localparam int SYMBOL_W   = 8;
   localparam int INDEX_W    = 6;
   localparam int CSR_DATA_W = 7;
   localparam int POS_W      = 32;
   localparam int COUNT_W    = 7;

   // Reset values of the configuration registers.
   localparam logic [CSR_DATA_W-1:0] LENGTH_RESET    = 7'd1;
   localparam logic [CSR_DATA_W-1:0] THRESHOLD_RESET = 7'd0;

   // Mismatch bits are first counted in groups of this size.
   localparam int GROUP_SIZE = 8;
   localparam int GROUP_W    = 4;

   typedef struct packed {
      logic shift;   // text transaction accepted: window moves one cell
      logic load;    // pattern write lands in this cell
      logic rotate;  // pattern ring steps one cell toward alignment
      logic active;  // cell lies inside the current window length
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== src/hws_cell.sv =====
// One cell of the search row: a window byte, a pattern byte and its mismatch flag.
// Depends on hws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hws_cell import hws_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cell_ctrl_type       ctrl,
   input  wire logic [SYMBOL_W-1:0] load_symbol,
   input  wire logic [SYMBOL_W-1:0] win_prev,
   input  wire logic [SYMBOL_W-1:0] pat_prev,
   output      logic [SYMBOL_W-1:0] win_out,
   output      logic [SYMBOL_W-1:0] pat_out,
   output      logic                miss_out
);

   logic [SYMBOL_W-1:0] win_ff;
   logic [SYMBOL_W-1:0] pat_ff;
   logic                miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (ctrl.shift) begin
         win_ff <= win_prev;
      end
   end

   // The flag compares the byte entering this cell with the pattern byte.
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         miss_ff <= ctrl.active && (win_prev != pat_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         pat_ff <= load_symbol;
      end else if (ctrl.rotate) begin
         pat_ff <= pat_prev;
      end
   end

   assign win_out  = win_ff;
   assign pat_out  = pat_ff;
   assign miss_out = miss_ff;

endmodule

`default_nettype wire

// ===== src/hws_count.sv =====
// Registered adder tree that counts mismatch flags, checks the threshold and
// holds the result register. Depends on hws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hws_count import hws_pkg::*; #(
   parameter int P = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [P-1:0]          in_miss,
   input  wire logic [POS_W-1:0]      in_pos,
   input  wire logic [CSR_DATA_W-1:0] thr,
   output      logic                  out_valid,
   output      logic [((($clog2(P+1)) > COUNT_W) ? $clog2(P+1) : COUNT_W)-1:0] out_count,
   output      logic [POS_W-1:0]      out_pos
);

   localparam int CW = $clog2(P + 1);
   localparam int TW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int G  = (P + GROUP_SIZE - 1) / GROUP_SIZE;

   logic [G*GROUP_SIZE-1:0] miss_pad;
   logic [GROUP_W-1:0]      grp_in [G];
   logic [GROUP_W-1:0]      grp_ff [G];
   logic                    s2_valid_ff;
   logic [POS_W-1:0]        s2_pos_ff;
   logic [TW-1:0]           sum_in;
   logic                    hit;
   logic                    out_valid_ff;
   logic [TW-1:0]           out_count_ff;
   logic [POS_W-1:0]        out_pos_ff;

   always_comb begin
      miss_pad = '0;
      miss_pad[P-1:0] = in_miss;
      for (int g = 0; g < G; g++) begin
         grp_in[g] = '0;
         for (int b = 0; b < GROUP_SIZE; b++) begin
            grp_in[g] = grp_in[g] + GROUP_W'(miss_pad[g*GROUP_SIZE + b]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_pos_ff <= in_pos;
         for (int g = 0; g < G; g++) begin
            grp_ff[g] <= grp_in[g];
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int g = 0; g < G; g++) begin
         sum_in = sum_in + TW'(grp_ff[g]);
      end
      hit = (sum_in <= TW'(thr));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= s2_valid_ff && hit;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_count_ff <= sum_in;
         out_pos_ff   <= s2_pos_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_count = out_count_ff;
   assign out_pos   = out_pos_ff;

endmodule

`default_nettype wire

// ===== src/hamming_window_search_top.sv =====
// Top level of the Hamming k-mismatch window search: configuration registers,
// position counter, the row of search cells and the mismatch counter.
// Depends on hws_pkg, hws_cell and hws_count.
`timescale 1ns / 1ps
`default_nettype none

//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+------------------------------------------
//  req     | in        | req_valid / req_ready | operation, symbol, pattern_index, restart
//  rsp     | out       | rsp_valid / rsp_ready | start_position, mismatch_count
//  csr     | in        | csr_valid / csr_ready | index, data (pattern_length, threshold)
//
// One request transaction is taken every cycle unless rsp stalls or the pattern ring realigns.
// A match passes three register stages (the cell row, the group count stage and the final sum
// stage) before rsp_valid rises. A stalled rsp freezes all three stages together and holds
// req_ready low while it lasts. After pattern_length changes, the pattern ring steps one cell
// per cycle into its new alignment, and req_ready stays low until it gets there; the alignment
// follows the effective length (zero counts as one, past the depth as the depth).
// Reset clears the window, position counter and pipeline at once; there is no clearing pass.

module hamming_window_search_top import hws_pkg::*; #(
   parameter int PATTERN_MAX = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic                   req_operation,
   input  wire logic [SYMBOL_W-1:0]    req_symbol,
   input  wire logic [INDEX_W-1:0]     req_pattern_index,
   input  wire logic                   req_restart,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [POS_W-1:0]       rsp_start_position,
   output      logic [COUNT_W-1:0]     rsp_mismatch_count,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int P   = PATTERN_MAX;
   localparam int AW  = (P > 1) ? $clog2(P) : 1;
   localparam int CW  = $clog2(P + 1);
   localparam int TW  = (CW > COUNT_W) ? CW : COUNT_W;
   // Wide enough for the length register, the ring depth and the pattern index.
   localparam int EW0 = (CW > CSR_DATA_W) ? CW : CSR_DATA_W;
   localparam int EW  = ((EW0 > INDEX_W) ? EW0 : INDEX_W) + 1;
   localparam logic [POS_W-1:0] SEEN_MAX = '1;

   // Configuration registers.
   logic [CSR_DATA_W-1:0] len_ff;
   logic [CSR_DATA_W-1:0] thr_ff;

   // Pattern ring alignment: cell j holds pattern[(al_ff - j) mod P].
   logic [AW-1:0]  al_ff;
   logic [AW-1:0]  al_in;
   logic [AW-1:0]  al_target;
   logic           aligned;

   logic [EW-1:0]  len_ext;
   logic [EW-1:0]  eff_len;
   logic [EW-1:0]  idx_ext;
   logic [EW-1:0]  al_ext;
   logic [EW-1:0]  tgt_ext;
   logic [AW-1:0]  tgt_cell;
   logic           idx_ok;

   logic           en;
   logic           req_acc;
   logic           text_acc;
   logic           pat_acc;

   logic [POS_W-1:0] seen_ff;
   logic [POS_W-1:0] seen_base;
   logic [POS_W-1:0] seen_in;
   logic             full_in;
   logic             s1_valid_ff;
   logic [POS_W-1:0] s1_pos_ff;

   cell_ctrl_type       cell_ctrl [P];
   logic [SYMBOL_W-1:0] win [P];
   logic [SYMBOL_W-1:0] pat [P];
   logic [P-1:0]        miss;

   logic [TW-1:0]    count_full;
   logic [POS_W-1:0] count_pos;
   logic             count_valid;

   // ---------------------------------------------------------------------------------------
   // Config port, always ready. The user writes only while the block is idle; not enforced.
   // ---------------------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LENGTH_RESET;
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH:     len_ff <= csr_data;
            CSR_MISMATCH_THRESHOLD: thr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective window length: zero acts as one, anything past the ring depth as the depth.
   always_comb begin
      len_ext = EW'(len_ff);
      if (len_ext == '0) begin
         eff_len = EW'(1);
      end else if (len_ext > EW'(P)) begin
         eff_len = EW'(P);
      end else begin
         eff_len = len_ext;
      end
      al_target = AW'(eff_len - EW'(1));
   end

   assign aligned = (al_ff == al_target);
   assign al_in   = (al_ff == AW'(P - 1)) ? '0 : al_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         al_ff <= '0;
      end else if (!aligned) begin
         al_ff <= al_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Request handshake. All pipeline stages move together unless rsp stalls.
   // ---------------------------------------------------------------------------------------
   assign en        = !count_valid || rsp_ready;
   assign req_ready = en && aligned;
   assign req_acc   = req_valid && req_ready;
   assign text_acc  = req_acc && (req_operation == OP_TEXT);
   assign pat_acc   = req_acc && (req_operation == OP_PATTERN);

   // Pattern writes go to the cell that the current alignment assigns to the slot.
   always_comb begin
      idx_ext = EW'(req_pattern_index);
      al_ext  = EW'(al_ff);
      idx_ok  = (idx_ext < EW'(P));
      if (al_ext >= idx_ext) begin
         tgt_ext = al_ext - idx_ext;
      end else begin
         tgt_ext = al_ext + EW'(P) - idx_ext;
      end
      tgt_cell = AW'(tgt_ext);
   end

   // Position counter; it restarts at a marked text symbol and saturates at its top value.
   always_comb begin
      seen_base = req_restart ? '0 : seen_ff;
      seen_in   = (seen_base == SEEN_MAX) ? SEEN_MAX : seen_base + POS_W'(1);
      full_in   = (seen_in >= POS_W'(eff_len));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (text_acc) begin
            seen_ff <= seen_in;
         end
         if (en) begin
            s1_valid_ff <= text_acc && full_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (text_acc) begin
         s1_pos_ff <= seen_in - POS_W'(eff_len);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Row of cells. The window shifts from cell 0 upward; the pattern ring rotates the same way.
   // ---------------------------------------------------------------------------------------
   for (genvar j = 0; j < P; j++) begin : g_cell
      localparam int PREV = (j == 0) ? P - 1 : j - 1;
      logic [SYMBOL_W-1:0] win_prev;

      if (j == 0) begin : g_head
         assign win_prev = req_symbol;
      end else begin : g_body
         assign win_prev = win[PREV];
      end

      always_comb begin
         cell_ctrl[j].shift  = text_acc;
         cell_ctrl[j].load   = pat_acc && idx_ok && (tgt_cell == AW'(j));
         cell_ctrl[j].rotate = !aligned;
         cell_ctrl[j].active = (EW'(j) < eff_len);
      end

      hws_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl[j]),
         .load_symbol (req_symbol),
         .win_prev    (win_prev),
         .pat_prev    (pat[PREV]),
         .win_out     (win[j]),
         .pat_out     (pat[j]),
         .miss_out    (miss[j])
      );
   end

   // ---------------------------------------------------------------------------------------
   // Mismatch count, threshold check and result register.
   // ---------------------------------------------------------------------------------------
   hws_count #(
      .P (P)
   ) u_count (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid_ff),
      .in_miss   (miss),
      .in_pos    (s1_pos_ff),
      .thr       (thr_ff),
      .out_valid (count_valid),
      .out_count (count_full),
      .out_pos   (count_pos)
   );

   assign rsp_valid          = count_valid;
   assign rsp_start_position = count_pos;
   assign rsp_mismatch_count = count_full[COUNT_W-1:0];

   // ---------------------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------------------
   // A reported window never holds more mismatches than the threshold allows.
   a_count_within_threshold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_full <= TW'(thr_ff)))
      else $error("reported mismatch count exceeds the threshold");

   // The first stage only fills from a text transaction that completed a window.
   a_stage_from_text : assert property (@(posedge clock) disable iff (reset)
      ($past(en) && s1_valid_ff) |->
         $past(req_valid && req_ready && (req_operation == OP_TEXT)))
      else $error("first stage valid without a text transaction");

   // The pattern ring only moves while it is out of alignment.
   a_ring_moves_when_unaligned : assert property (@(posedge clock) disable iff (reset)
      !$stable(al_ff) |-> $past(!aligned))
      else $error("pattern ring rotated while aligned");

endmodule

`default_nettype wire

// ===== sim/hws_match_checker.sv =====
`timescale 1ns / 1ps
// Match checker for the Hamming window search: watches the request, result and register
// channels, predicts every reported window and compares it with the block's output.
// Depends on hws_pkg for field widths, operation codes and register indexes.

module hws_match_checker import hws_pkg::*; #(
   parameter int PATTERN_MAX = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire logic                   req_operation,
   input  wire logic [SYMBOL_W-1:0]    req_symbol,
   input  wire logic [INDEX_W-1:0]     req_pattern_index,
   input  wire logic                   req_restart,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire logic [POS_W-1:0]       rsp_start_position,
   input  wire logic [COUNT_W-1:0]     rsp_mismatch_count,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output int                          pending,
   output int                          failures
);

   typedef struct packed {
      logic [POS_W-1:0]   start_position;
      logic [COUNT_W-1:0] mismatch_count;
   } match_type;

   logic [SYMBOL_W-1:0]   pattern_mem [PATTERN_MAX];
   logic [SYMBOL_W-1:0]   text_window [PATTERN_MAX];
   logic [POS_W-1:0]      symbols_in_text;
   logic [CSR_DATA_W-1:0] length_reg;
   logic [CSR_DATA_W-1:0] threshold_reg;
   match_type             match_q [$];
   int                    fail_count = 0;

   // A length of zero compares one symbol; anything above the store compares all of it.
   function automatic int unsigned compare_span();
      if (length_reg == 0) begin
         return 1;
      end
      if (length_reg > PATTERN_MAX) begin
         return PATTERN_MAX;
      end
      return 32'(length_reg);
   endfunction

   task automatic take_text(input logic [SYMBOL_W-1:0] sym, input logic restart);
      int unsigned span;
      int unsigned miss;
      match_type   hit;
      if (restart) begin
         symbols_in_text = '0;
      end
      for (int i = PATTERN_MAX - 1; i > 0; i--) begin
         text_window[i] = text_window[i-1];
      end
      text_window[0] = sym;
      if (symbols_in_text != '1) begin
         symbols_in_text++;
      end
      span = compare_span();
      if (symbols_in_text < span) begin
         return;
      end
      miss = 0;
      for (int k = 0; k < span; k++) begin
         if (text_window[span-1-k] != pattern_mem[k]) begin
            miss++;
         end
      end
      if (miss > threshold_reg) begin
         return;
      end
      hit.start_position = symbols_in_text - span;
      hit.mismatch_count = miss[COUNT_W-1:0];
      match_q.insert(match_q.size(), hit);
   endtask

   always @(posedge clock) begin
      match_type got;
      match_type want;
      if (reset) begin
         for (int i = 0; i < PATTERN_MAX; i++) begin
            text_window[i] = '0;
         end
         symbols_in_text = '0;
         length_reg      = LENGTH_RESET;
         threshold_reg   = THRESHOLD_RESET;
         match_q.delete();
      end else begin
         // Results are taken before this edge's request, which cannot answer in the same cycle.
         if (rsp_valid && rsp_ready) begin
            got.start_position = rsp_start_position;
            got.mismatch_count = rsp_mismatch_count;
            if (match_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%t: unexpected match, position %0d count %0d", $realtime,
                           got.start_position, got.mismatch_count);
               end
            end else begin
               want = match_q.pop_front();
               if (got.start_position !== want.start_position ||
                   got.mismatch_count !== want.mismatch_count) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%t: match differs, expected position %0d count %0d, got %0d %0d",
                              $realtime, want.start_position, want.mismatch_count,
                              got.start_position, got.mismatch_count);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATTERN_LENGTH: begin
                  length_reg = csr_data;
               end
               CSR_MISMATCH_THRESHOLD: begin
                  threshold_reg = csr_data;
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_operation == OP_PATTERN) begin
               if (req_pattern_index < PATTERN_MAX) begin
                  pattern_mem[req_pattern_index] = req_symbol;
               end
            end else begin
               take_text(req_symbol, req_restart);
            end
         end
      end
      pending  <= match_q.size();
      failures <= fail_count;
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for hamming_window_search_top: clock, reset, request and register stimulus,
// receiver back-pressure, a stall watchdog and the final verdict.
// Depends on hws_pkg, the block itself and hws_match_checker.

module tb_top;
   import hws_pkg::*;

   localparam int PATTERN_MAX   = 64;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 105;
   // Long receiver hold-off used once to fill the pipeline and push back on requests.
   localparam int HOLD_CYCLES   = 300;
   // Lets requests that report nothing leave the pipeline after the last predicted match.
   localparam int SETTLE_CYCLES = 8;
   // Cycles without any transaction before the run is declared hung. The slowest legal
   // stretch is the hold-off above plus a full pattern ring realignment.
   localparam int STALL_LIMIT   = 4000;

   logic                   clock             = 1'b0;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_ready;
   logic                   req_operation     = OP_TEXT;
   logic [SYMBOL_W-1:0]    req_symbol        = '0;
   logic [INDEX_W-1:0]     req_pattern_index = '0;
   logic                   req_restart       = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready         = 1'b0;
   logic [POS_W-1:0]       rsp_start_position;
   logic [COUNT_W-1:0]     rsp_mismatch_count;
   logic                   csr_valid         = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index         = CSR_PATTERN_LENGTH;
   logic [CSR_DATA_W-1:0]  csr_data          = '0;

   // Idle rates in percent. The sender's is used only by the stimulus process; the
   // receiver's is changed with nonblocking assignments and read by the receiver process.
   int send_idle_pct = 22;
   int rsp_idle_pct  = 73;

   // The stimulus asks for a hold-off by bumping hold_asks; the receiver serves it.
   int hold_asks    = 0;
   int hold_served  = 0;
   int hold_left    = 0;
   int quiet_cycles = 0;

   int pending;
   int mismatches;

   // Stimulus copy of the pattern store, used to build windows that nearly match.
   logic [SYMBOL_W-1:0] pattern_copy [PATTERN_MAX];
   int                  window_len = 1;

   always #5 clock = ~clock;

   hamming_window_search_top #(
      .PATTERN_MAX(PATTERN_MAX)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_symbol         (req_symbol),
      .req_pattern_index  (req_pattern_index),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_start_position (rsp_start_position),
      .rsp_mismatch_count (rsp_mismatch_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   hws_match_checker #(
      .PATTERN_MAX(PATTERN_MAX)
   ) match_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_symbol         (req_symbol),
      .req_pattern_index  (req_pattern_index),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_start_position (rsp_start_position),
      .rsp_mismatch_count (rsp_mismatch_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .pending            (pending),
      .failures           (mismatches)
   );

   // Receiver: random ready at the current idle rate, except during a requested hold-off,
   // which it counts out itself while the sender keeps offering requests.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asks != hold_served) begin
         rsp_ready   <= 1'b0;
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog: any transaction on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Mostly a small alphabet so that windows often match, with full bytes mixed in.
   function automatic logic [SYMBOL_W-1:0] pick_symbol();
      if ($urandom_range(3) != 0) begin
         return SYMBOL_W'($urandom_range(3));
      end
      return SYMBOL_W'($urandom_range(255));
   endfunction

   // Offers one request transaction, possibly after an idle gap, and returns at the edge
   // where it is accepted. Valid stays high between back-to-back transactions.
   task automatic offer_item(input logic op, input logic [SYMBOL_W-1:0] sym,
                             input logic [INDEX_W-1:0] slot, input logic restart);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_symbol        <= sym;
      req_pattern_index <= slot;
      req_restart       <= restart;
      if (op == OP_PATTERN) begin
         pattern_copy[slot] = sym;
      end
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops offering, waits until every predicted match has arrived, then lets the pipeline
   // empty of requests that report nothing.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers in two back-to-back transactions; only called when idle.
   task automatic configure(input logic [CSR_DATA_W-1:0] len, input logic [CSR_DATA_W-1:0] thr);
      csr_valid <= 1'b1;
      csr_index <= CSR_PATTERN_LENGTH;
      csr_data  <= len;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_MISMATCH_THRESHOLD;
      csr_data  <= thr;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (len == 0) begin
         window_len = 1;
      end else if (len > PATTERN_MAX) begin
         window_len = PATTERN_MAX;
      end else begin
         window_len = len;
      end
   endtask

   initial begin
      int                    items;
      int                    pick;
      int                    flip_pct;
      logic                  fresh;
      logic [SYMBOL_W-1:0]   sym;
      logic [CSR_DATA_W-1:0] len_val;
      logic [CSR_DATA_W-1:0] thr_val;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Fill every pattern slot first, so that no comparison ever reads an unwritten one.
      // Restart is random here: it must be ignored on pattern writes.
      for (int s = 0; s < PATTERN_MAX; s++) begin
         offer_item(OP_PATTERN, pick_symbol(), INDEX_W'(s), 1'($urandom_range(1)));
      end

      // Directed part. A length of zero must behave as one symbol.
      wait_idle();
      configure(7'd0, 7'd0);
      offer_item(OP_PATTERN, 8'd0, 6'd0, 1'b1);
      offer_item(OP_PATTERN, 8'd255, 6'd63, 1'b0);
      offer_item(OP_TEXT, 8'd0, 6'd63, 1'b1);     // exact match at offset 0
      offer_item(OP_TEXT, 8'd255, 6'd0, 1'b0);    // one mismatch over threshold 0
      offer_item(OP_TEXT, 8'd0, 6'd0, 1'b0);      // match at offset 2

      // Two-symbol pattern {0, 255}: a text shorter than the pattern reports nothing,
      // and a restart leaves stale window contents that must not be compared.
      wait_idle();
      configure(7'd2, 7'd1);
      offer_item(OP_PATTERN, 8'd255, 6'd1, 1'b0);
      offer_item(OP_TEXT, 8'd0, 6'd0, 1'b1);
      offer_item(OP_TEXT, 8'd255, 6'd0, 1'b1);
      offer_item(OP_TEXT, 8'd255, 6'd0, 1'b0);    // one mismatch, within threshold
      offer_item(OP_TEXT, 8'd0, 6'd0, 1'b0);      // two mismatches
      offer_item(OP_TEXT, 8'd255, 6'd0, 1'b0);    // exact match

      // Random phases. Each starts from an idle block with a new register setting; the
      // first ones cover the extremes (oversized length, thresholds of 64 and above).
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         if (ph == 4) begin
            send_idle_pct = 73;
            rsp_idle_pct  <= 22;
         end
         if (ph == 8) begin
            send_idle_pct = 0;
            rsp_idle_pct  <= 0;
         end
         case (ph)
            0: begin
               len_val = 7'd127;
               thr_val = 7'd127;
            end
            1: begin
               len_val = 7'd64;
               thr_val = 7'd64;
            end
            2: begin
               len_val = 7'd65;
               thr_val = 7'd3;
            end
            3: begin
               len_val = 7'd1;
               thr_val = 7'd0;
            end
            4: begin
               len_val = 7'd0;
               thr_val = 7'd127;
            end
            9: begin
               // Every full window reports, so the hold-off below backs the block up.
               len_val = 7'($urandom_range(2, 6));
               thr_val = 7'd127;
            end
            default: begin
               if ($urandom_range(5) == 0) begin
                  len_val = 7'($urandom_range(9, 64));
                  thr_val = 7'($urandom_range(0, 64));
               end else begin
                  len_val = 7'($urandom_range(1, 8));
                  thr_val = 7'($urandom_range(0, 3));
               end
            end
         endcase
         configure(len_val, thr_val);
         if (ph == 9) begin
            hold_asks <= hold_asks + 1;
         end

         offer_item(OP_TEXT, pick_symbol(), INDEX_W'($urandom), 1'b1);
         items = 1;
         while (items < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               // Pattern rewrite in the middle of a text.
               offer_item(OP_PATTERN, pick_symbol(), INDEX_W'($urandom),
                          1'($urandom_range(1)));
               items++;
            end else if (pick < 58) begin
               // A copy of the pattern with a few symbols changed, sometimes as a new text.
               flip_pct = $urandom_range(15);
               fresh    = ($urandom_range(3) == 0);
               for (int k = 0; k < window_len; k++) begin
                  sym = pattern_copy[k];
                  if ($urandom_range(99) < flip_pct) begin
                     sym = pick_symbol();
                  end
                  offer_item(OP_TEXT, sym, INDEX_W'($urandom), fresh && k == 0);
                  items++;
               end
            end else if (pick < 65) begin
               // Restart in the middle of a window.
               offer_item(OP_TEXT, pick_symbol(), INDEX_W'($urandom), 1'b1);
               items++;
            end else begin
               offer_item(OP_TEXT, pick_symbol(), INDEX_W'($urandom), 1'b0);
               items++;
            end
         end
      end

      wait_idle();
      if (mismatches == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
